// File: hdl/aqsd_pkg.sv
// shared types, character codes and helpers for the address query splitter
`default_nettype none
package aqsd_pkg;

   localparam int CharWidth = 8;

   localparam logic [CharWidth-1:0] CH_SLASH = 8'h2F;
   localparam logic [CharWidth-1:0] CH_QUEST = 8'h3F;
   localparam logic [CharWidth-1:0] CH_EQUAL = 8'h3D;
   localparam logic [CharWidth-1:0] CH_AMP   = 8'h26;
   localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CharWidth-1:0] CH_PCT   = 8'h25;
   localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_NAMESPACE = 2'd0,
      KIND_PATH      = 2'd1,
      KIND_FIELD     = 2'd2,
      KIND_VALUE     = 2'd3
   } part_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_NO_EQUALS = 2'd2,
      STATUS_BAD_ESC   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_PCT  = 2'd1,
      ESC_HIGH = 2'd2,
      ESC_RSVD = 2'd3
   } esc_type;

   typedef struct packed {
      part_kind_type phase;
      esc_type       escape_stage;
      logic [3:0]    high_nibble;
      logic          field_open;
      logic          bad_escape_seen;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:           KIND_NAMESPACE,
      escape_stage:    ESC_NONE,
      high_nibble:     4'd0,
      field_open:      1'b0,
      bad_escape_seen: 1'b0
   };

   typedef struct packed {
      logic [CharWidth-1:0] out_char;
      logic                 char_valid;
      part_kind_type        part_kind;
      logic                 part_end;
      logic                 done_res;
      status_type           status;
   } result_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [CharWidth-1:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
      else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h41 + 8'd10)};
      else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h61 + 8'd10)};
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hdl/aqsd_step.sv
// next-state and result logic for one address byte
`default_nettype none
module aqsd_step (
   input  wire aqsd_pkg::parse_state_type              cur,
   input  wire logic [aqsd_pkg::CharWidth-1:0]         in_byte,
   input  wire logic                                   is_last,
   output aqsd_pkg::parse_state_type                   nxt,
   output aqsd_pkg::result_type                        res
);

   always_comb begin
      logic [aqsd_pkg::CharWidth-1:0] delim;
      logic [4:0]                     hx;

      nxt   = cur;
      res   = '0;
      res.part_kind = cur.phase;
      hx    = aqsd_pkg::hex_decode(in_byte);

      unique case (cur.phase)
         aqsd_pkg::KIND_NAMESPACE: delim = aqsd_pkg::CH_SLASH;
         aqsd_pkg::KIND_PATH:      delim = aqsd_pkg::CH_QUEST;
         aqsd_pkg::KIND_FIELD:     delim = aqsd_pkg::CH_EQUAL;
         default:                  delim = aqsd_pkg::CH_AMP;
      endcase

      if (in_byte == delim) begin
         // pending escape is cut off by the delimiter
         if (cur.escape_stage == aqsd_pkg::ESC_PCT || cur.escape_stage == aqsd_pkg::ESC_HIGH)
            nxt.bad_escape_seen = 1'b1;
         nxt.escape_stage = aqsd_pkg::ESC_NONE;
         nxt.high_nibble  = 4'd0;
         res.part_end     = 1'b1;
         unique case (cur.phase)
            aqsd_pkg::KIND_NAMESPACE: begin
               res.out_char   = aqsd_pkg::CH_SLASH;
               res.char_valid = 1'b1;
               nxt.phase      = aqsd_pkg::KIND_PATH;
            end
            aqsd_pkg::KIND_FIELD: begin
               nxt.phase = aqsd_pkg::KIND_VALUE;
            end
            default: begin
               nxt.phase      = aqsd_pkg::KIND_FIELD;
               nxt.field_open = 1'b0;
            end
         endcase
      end else begin
         if (cur.phase == aqsd_pkg::KIND_FIELD)
            nxt.field_open = 1'b1;
         case (cur.escape_stage)
            aqsd_pkg::ESC_PCT: begin
               if (hx[4]) begin
                  nxt.high_nibble  = hx[3:0];
                  nxt.escape_stage = aqsd_pkg::ESC_HIGH;
               end else begin
                  nxt.bad_escape_seen = 1'b1;
                  nxt.escape_stage    = aqsd_pkg::ESC_NONE;
               end
            end
            aqsd_pkg::ESC_HIGH: begin
               if (hx[4]) begin
                  res.out_char   = {cur.high_nibble, hx[3:0]};
                  res.char_valid = 1'b1;
               end else begin
                  nxt.bad_escape_seen = 1'b1;
               end
               nxt.escape_stage = aqsd_pkg::ESC_NONE;
               nxt.high_nibble  = 4'd0;
            end
            default: begin
               if (in_byte == aqsd_pkg::CH_PCT) begin
                  nxt.escape_stage = aqsd_pkg::ESC_PCT;
               end else if (in_byte == aqsd_pkg::CH_PLUS) begin
                  res.out_char   = aqsd_pkg::CH_SPACE;
                  res.char_valid = 1'b1;
               end else begin
                  res.out_char   = in_byte;
                  res.char_valid = 1'b1;
               end
            end
         endcase
      end

      if (is_last) begin
         res.done_res = 1'b1;
         if (nxt.phase == aqsd_pkg::KIND_NAMESPACE)
            res.status = aqsd_pkg::STATUS_EMPTY;
         else if (nxt.phase == aqsd_pkg::KIND_FIELD && nxt.field_open)
            res.status = aqsd_pkg::STATUS_NO_EQUALS;
         else if (nxt.bad_escape_seen || nxt.escape_stage == aqsd_pkg::ESC_PCT
                  || nxt.escape_stage == aqsd_pkg::ESC_HIGH)
            res.status = aqsd_pkg::STATUS_BAD_ESC;
         else
            res.status = aqsd_pkg::STATUS_OK;
         nxt = aqsd_pkg::STATE_RESET;
      end
   end

endmodule
`default_nettype wire

// File: hdl/address_query_splitter_decoder_top.sv
// top level of the address splitter and url decoder: input stage, step logic, result stage
// an accepted item passes through the input register and then the result register;
// rsp_valid rises once the item has moved from the input stage into the result stage
// throughput: one item per cycle while rsp_ready stays high, as the parser state updates once per item
// the input stage takes a new item while a result waits, provided the input stage is empty
// reset: synchronous, active high; clears stage valids and returns the parser to the namespace
// phase with no escape pending and all flags cleared
`default_nettype none
module address_query_splitter_decoder_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [aqsd_pkg::CharWidth-1:0]   req_in_byte,
   input  wire logic                             req_is_last,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [aqsd_pkg::CharWidth-1:0]   rsp_out_char,
   output logic                                  rsp_char_valid,
   output logic      [1:0]                       rsp_part_kind,
   output logic                                  rsp_part_end,
   output logic                                  rsp_done_res,
   output logic      [1:0]                       rsp_status
);

   // input stage
   logic                           in_valid_ff, in_valid_in;
   logic [aqsd_pkg::CharWidth-1:0] in_byte_ff;
   logic                           in_last_ff;

   // parser state, updated when an item moves into the result stage
   aqsd_pkg::parse_state_type state_ff, state_in;

   // result stage
   logic                 out_valid_ff, out_valid_in;
   aqsd_pkg::result_type out_ff, res_in;

   logic out_load;  // input stage item moves to result stage

   assign out_load    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || out_load;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   aqsd_step u_step (
      .cur     (state_ff),
      .in_byte (in_byte_ff),
      .is_last (in_last_ff),
      .nxt     (state_in),
      .res     (res_in)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= aqsd_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load)
            state_ff <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_is_last;
      end
      if (out_load)
         out_ff <= res_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_char   = out_ff.out_char;
   assign rsp_char_valid = out_ff.char_valid;
   assign rsp_part_kind  = out_ff.part_kind;
   assign rsp_part_end   = out_ff.part_end;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_status     = out_ff.status;

   // a last item leaves the parser back in its reset state
   a_last_resets: assert property (@(posedge clock) disable iff (reset)
      out_load && in_last_ff |=> state_ff == aqsd_pkg::STATE_RESET)
      else $error("parser state not cleared after last item");

   // status only carries meaning on the closing item
   a_status_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_status == aqsd_pkg::STATUS_OK)
      else $error("status set without done");

   // only the slash that opens the path both closes a part and carries a character
   a_end_with_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_part_end && rsp_char_valid |->
         rsp_part_kind == aqsd_pkg::KIND_NAMESPACE && rsp_out_char == aqsd_pkg::CH_SLASH)
      else $error("part end with character outside namespace close");

   // no character means a zero character
   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_out_char == '0)
      else $error("out_char nonzero without char_valid");

endmodule
`default_nettype wire
